/* hw/rtl/dsa_pkg.sv */
// dsa_pkg: shared types, sizes and codes for the descriptor slot allocator.
// No dependencies.
package dsa_pkg;

    localparam int MAX_SLOTS   = 1024;
    localparam int FRAME_COUNT = 3;
    localparam int SLOT_W      = $clog2(MAX_SLOTS);
    localparam int CNT_W       = SLOT_W + 1;
    localparam int FRAME_W     = 2;
    localparam int FIDX_W      = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int ADDR_W      = 48;
    localparam int CAP_W       = 11;
    localparam int DSIZE_W     = 13;
    localparam int PROD_W      = SLOT_W + DSIZE_W;
    localparam int STAT_W      = 3;
    localparam int ACT_W       = 2;
    localparam int CIDX_W      = 3;
    localparam int TOTAL_W     = CNT_W + $clog2(FRAME_COUNT + 1);

    localparam logic [ACT_W-1:0] ACT_ALLOC  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FREE   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DRAIN  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 3'd2;
    localparam logic [STAT_W-1:0] ST_BAD   = 3'd3;
    localparam logic [STAT_W-1:0] ST_NULL  = 3'd4;

    localparam logic [CIDX_W-1:0] CFG_CAPACITY = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_DSIZE    = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_VISIBLE  = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_CPU_BASE = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_GPU_BASE = 3'd4;

    typedef struct packed {
        logic [CAP_W-1:0]   capacity;
        logic [DSIZE_W-1:0] dsize;
        logic               visible;
        logic [ADDR_W-1:0]  cpu_base;
        logic [ADDR_W-1:0]  gpu_base;
    } cfg_t;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [ADDR_W-1:0]  addr;
        logic [FRAME_W-1:0] frame;
        logic               is_null;
        logic               frame_bad;
    } cmd_t;

    typedef struct packed {
        logic clearing;
        logic idle;
    } back_stat_t;

endpackage

/* hw/rtl/dsa_if.sv */
// dsa_in_if / dsa_out_if: valid/ready channels of the allocator.
// Depends on dsa_pkg.
interface dsa_in_if;
    logic                        valid;
    logic                        ready;
    logic [dsa_pkg::ACT_W-1:0]   action;
    logic [dsa_pkg::ADDR_W-1:0]  handle_address;
    logic [dsa_pkg::FRAME_W-1:0] frame_slot;

    modport source (output valid, action, handle_address, frame_slot, input ready);
    modport sink   (input valid, action, handle_address, frame_slot, output ready);
endinterface

interface dsa_out_if;
    logic                        valid;
    logic                        ready;
    logic [dsa_pkg::STAT_W-1:0]  status;
    logic [dsa_pkg::ADDR_W-1:0]  cpu_address;
    logic [dsa_pkg::ADDR_W-1:0]  gpu_address;
    logic [dsa_pkg::SLOT_W-1:0]  slot_index;

    modport source (output valid, status, cpu_address, gpu_address, slot_index, input ready);
    modport sink   (input valid, status, cpu_address, gpu_address, slot_index, output ready);
endinterface

/* hw/rtl/dsa_front.sv */
// dsa_front: accepts input words, classifies them, queues them two deep.
// Depends on dsa_pkg and dsa_if.
module dsa_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    dsa_in_if.sink               in_ch,
    input  logic                 hold,
    output logic                 q_valid,
    input  logic                 q_ready,
    output dsa_pkg::cmd_t        q_word
);

    dsa_pkg::cmd_t q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;
    dsa_pkg::cmd_t cmd;

    assign in_ch.ready = (cnt_reg != 2'd2) && !hold;
    assign push = in_ch.valid && in_ch.ready;
    assign pop  = q_valid && q_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_word  = q_reg[rd_ptr_reg];

    always_comb
    begin
        cmd.action    = in_ch.action;
        cmd.addr      = in_ch.handle_address;
        cmd.frame     = in_ch.frame_slot;
        cmd.is_null   = (in_ch.handle_address == '0);
        cmd.frame_bad = ({30'd0, in_ch.frame_slot} >= 32'(dsa_pkg::FRAME_COUNT));
        wr_ptr_next   = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next   = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next      = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

/* hw/rtl/dsa_div.sv */
// dsa_div: restoring divider, one quotient bit per cycle.
// Depends on dsa_pkg.
module dsa_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [dsa_pkg::ADDR_W-1:0]    dividend,
    input  logic [dsa_pkg::DSIZE_W-1:0]   divisor,
    output logic                          done,
    output logic [dsa_pkg::ADDR_W-1:0]    quot,
    output logic [dsa_pkg::DSIZE_W-1:0]   rem
);

    localparam int STEP_W = $clog2(dsa_pkg::ADDR_W + 1);

    logic [dsa_pkg::ADDR_W-1:0]  q_reg, q_next;
    logic [dsa_pkg::DSIZE_W-1:0] r_reg, r_next;
    logic [dsa_pkg::DSIZE_W-1:0] d_reg, d_next;
    logic [STEP_W-1:0]           step_reg, step_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [dsa_pkg::DSIZE_W:0]   trial;
    logic                        fits;

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg;

    always_comb
    begin
        trial     = {r_reg, q_reg[dsa_pkg::ADDR_W-1]};
        fits      = (trial >= {1'b0, d_reg});
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next = {q_reg[dsa_pkg::ADDR_W-2:0], fits};
            r_next = fits ? dsa_pkg::DSIZE_W'(trial - {1'b0, d_reg})
                          : trial[dsa_pkg::DSIZE_W-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(dsa_pkg::ADDR_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

endmodule

/* hw/rtl/dsa_back.sv */
// dsa_back: executes queued words against the free stack and pending lists.
// Depends on dsa_pkg, dsa_if and dsa_div.
module dsa_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dsa_pkg::cfg_t        cfg,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  dsa_pkg::cmd_t        q_word,
    dsa_out_if.source            out_ch,
    output dsa_pkg::back_stat_t  stat
);

    localparam int SLOT_W  = dsa_pkg::SLOT_W;
    localparam int CNT_W   = dsa_pkg::CNT_W;
    localparam int ADDR_W  = dsa_pkg::ADDR_W;
    localparam int PADDR_W = dsa_pkg::FIDX_W + SLOT_W;

    localparam logic [3:0] S_CLEAR     = 4'd0;
    localparam logic [3:0] S_IDLE      = 4'd1;
    localparam logic [3:0] S_ALLOC_RD  = 4'd2;
    localparam logic [3:0] S_ALLOC_ADD = 4'd3;
    localparam logic [3:0] S_FREE_DIV  = 4'd4;
    localparam logic [3:0] S_DRAIN_RD  = 4'd5;
    localparam logic [3:0] S_DRAIN_WR  = 4'd6;
    localparam logic [3:0] S_DONE      = 4'd7;

    logic [SLOT_W-1:0] stack_mem [dsa_pkg::MAX_SLOTS];
    logic [SLOT_W-1:0] pend_mem  [dsa_pkg::FRAME_COUNT * dsa_pkg::MAX_SLOTS];

    logic [3:0]          state_reg, state_next;
    logic [CNT_W-1:0]    used_reg, used_next;
    logic [CNT_W-1:0]    pcnt_reg [dsa_pkg::FRAME_COUNT];
    logic [CNT_W-1:0]    pcnt_next [dsa_pkg::FRAME_COUNT];
    logic [CNT_W-1:0]    k_reg, k_next;
    logic [CNT_W-1:0]    clr_reg, clr_next;
    dsa_pkg::cmd_t       cur_reg, cur_next;
    logic [dsa_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic [dsa_pkg::STAT_W-1:0] res_st_reg, res_st_next;
    logic [ADDR_W-1:0]   res_cpu_reg, res_cpu_next;
    logic [ADDR_W-1:0]   res_gpu_reg, res_gpu_next;
    logic [SLOT_W-1:0]   res_slot_reg, res_slot_next;
    logic                ov_reg, ov_next;
    logic [dsa_pkg::STAT_W-1:0] o_st_reg;
    logic [ADDR_W-1:0]   o_cpu_reg, o_gpu_reg;
    logic [SLOT_W-1:0]   o_slot_reg;
    logic                o_load;

    logic [SLOT_W-1:0]   stk_raddr, stk_waddr, stk_wdata, stk_q;
    logic                stk_we;
    logic [PADDR_W-1:0]  pend_raddr, pend_waddr;
    logic [SLOT_W-1:0]   pend_wdata, pend_q;
    logic                pend_we;

    logic [CNT_W-1:0]    eff_cap;
    logic [dsa_pkg::TOTAL_W-1:0] ptotal;
    logic [dsa_pkg::FIDX_W-1:0]  fidx;
    logic                div_start, div_done;
    logic [ADDR_W-1:0]   div_q, diff;
    logic [dsa_pkg::DSIZE_W-1:0] div_r;

    assign fidx = cur_reg.frame[dsa_pkg::FIDX_W-1:0];
    assign diff = q_word.addr - cfg.cpu_base;
    assign stat.clearing = (state_reg == S_CLEAR);
    assign stat.idle     = (state_reg == S_IDLE);

    assign out_ch.valid       = ov_reg;
    assign out_ch.status      = o_st_reg;
    assign out_ch.cpu_address = o_cpu_reg;
    assign out_ch.gpu_address = o_gpu_reg;
    assign out_ch.slot_index  = o_slot_reg;

    dsa_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (diff),
        .divisor  (cfg.dsize),
        .done     (div_done),
        .quot     (div_q),
        .rem      (div_r)
    );

    always_comb
    begin
        eff_cap = (cfg.capacity > dsa_pkg::CAP_W'(dsa_pkg::MAX_SLOTS))
                ? CNT_W'(dsa_pkg::MAX_SLOTS) : CNT_W'(cfg.capacity);
        ptotal = '0;
        for (int f = 0; f < dsa_pkg::FRAME_COUNT; f++)
        begin
            ptotal = ptotal + dsa_pkg::TOTAL_W'(pcnt_reg[f]);
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        used_next     = used_reg;
        pcnt_next     = pcnt_reg;
        k_next        = k_reg;
        clr_next      = clr_reg;
        cur_next      = cur_reg;
        prod_next     = prod_reg;
        res_st_next   = res_st_reg;
        res_cpu_next  = res_cpu_reg;
        res_gpu_next  = res_gpu_reg;
        res_slot_next = res_slot_reg;
        q_ready       = 1'b0;
        div_start     = 1'b0;
        stk_raddr     = used_reg[SLOT_W-1:0];
        stk_we        = 1'b0;
        stk_waddr     = clr_reg[SLOT_W-1:0];
        stk_wdata     = clr_reg[SLOT_W-1:0];
        pend_raddr    = {fidx, k_reg[SLOT_W-1:0]};
        pend_we       = 1'b0;
        pend_waddr    = {fidx, pcnt_reg[fidx][SLOT_W-1:0]};
        pend_wdata    = div_q[SLOT_W-1:0];
        o_load        = 1'b0;
        ov_next       = ov_reg && !out_ch.ready;

        case (state_reg)
            S_CLEAR:
            begin
                stk_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CNT_W'(dsa_pkg::MAX_SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                stk_raddr     = used_reg[SLOT_W-1:0];
                q_ready       = 1'b1;
                res_st_next   = dsa_pkg::ST_OK;
                res_cpu_next  = '0;
                res_gpu_next  = '0;
                res_slot_next = '0;
                if (q_valid)
                begin
                    cur_next   = q_word;
                    state_next = S_DONE;
                    case (q_word.action)
                        dsa_pkg::ACT_ALLOC:
                        begin
                            if (used_reg >= eff_cap
                                || used_reg >= CNT_W'(dsa_pkg::MAX_SLOTS))
                            begin
                                res_st_next = dsa_pkg::ST_FULL;
                            end
                            else
                            begin
                                state_next = S_ALLOC_RD;
                            end
                        end
                        dsa_pkg::ACT_FREE:
                        begin
                            if (q_word.is_null)
                            begin
                                res_st_next = dsa_pkg::ST_NULL;
                            end
                            else if (ptotal >= dsa_pkg::TOTAL_W'(used_reg))
                            begin
                                res_st_next = dsa_pkg::ST_EMPTY;
                            end
                            else if (q_word.frame_bad || cfg.dsize == '0
                                     || q_word.addr < cfg.cpu_base)
                            begin
                                res_st_next = dsa_pkg::ST_BAD;
                            end
                            else
                            begin
                                div_start  = 1'b1;
                                state_next = S_FREE_DIV;
                            end
                        end
                        dsa_pkg::ACT_DRAIN:
                        begin
                            if (q_word.frame_bad)
                            begin
                                res_st_next = dsa_pkg::ST_BAD;
                            end
                            else
                            begin
                                k_next     = '0;
                                state_next = S_DRAIN_RD;
                            end
                        end
                        default:
                        begin
                            res_st_next = dsa_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_ALLOC_RD:
            begin
                prod_next     = dsa_pkg::PROD_W'(stk_q) * dsa_pkg::PROD_W'(cfg.dsize);
                res_slot_next = stk_q;
                state_next    = S_ALLOC_ADD;
            end
            S_ALLOC_ADD:
            begin
                res_cpu_next = cfg.cpu_base + ADDR_W'(prod_reg);
                res_gpu_next = cfg.visible ? (cfg.gpu_base + ADDR_W'(prod_reg)) : '0;
                used_next    = used_reg + 1'b1;
                state_next   = S_DONE;
            end
            S_FREE_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_DONE;
                    if (div_r != '0 || div_q >= ADDR_W'(eff_cap))
                    begin
                        res_st_next = dsa_pkg::ST_BAD;
                    end
                    else
                    begin
                        pend_we         = 1'b1;
                        pcnt_next[fidx] = pcnt_reg[fidx] + 1'b1;
                        res_slot_next   = div_q[SLOT_W-1:0];
                    end
                end
            end
            S_DRAIN_RD:
            begin
                if (k_reg < pcnt_reg[fidx] && used_reg != '0)
                begin
                    state_next = S_DRAIN_WR;
                end
                else
                begin
                    pcnt_next[fidx] = '0;
                    state_next      = S_DONE;
                end
            end
            S_DRAIN_WR:
            begin
                stk_we     = 1'b1;
                stk_waddr  = SLOT_W'(used_reg - 1'b1);
                stk_wdata  = pend_q;
                used_next  = used_reg - 1'b1;
                k_next     = k_reg + 1'b1;
                state_next = S_DRAIN_RD;
            end
            S_DONE:
            begin
                if (!ov_reg || out_ch.ready)
                begin
                    o_load     = 1'b1;
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stack_mem[stk_waddr] <= stk_wdata;
        end
        stk_q <= stack_mem[stk_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pend_we)
        begin
            pend_mem[pend_waddr] <= pend_wdata;
        end
        pend_q <= pend_mem[pend_raddr];
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        prod_reg     <= prod_next;
        res_st_reg   <= res_st_next;
        res_cpu_reg  <= res_cpu_next;
        res_gpu_reg  <= res_gpu_next;
        res_slot_reg <= res_slot_next;
        k_reg        <= k_next;
        if (o_load)
        begin
            o_st_reg   <= res_st_reg;
            o_cpu_reg  <= res_cpu_reg;
            o_gpu_reg  <= res_gpu_reg;
            o_slot_reg <= res_slot_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            used_reg  <= '0;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
            for (int f = 0; f < dsa_pkg::FRAME_COUNT; f++)
            begin
                pcnt_reg[f] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            clr_reg   <= clr_next;
            ov_reg    <= ov_next;
            pcnt_reg  <= pcnt_next;
        end
    end

endmodule

/* hw/rtl/descriptor_slot_allocator.sv */
// descriptor_slot_allocator: top level, configuration registers, front and back.
// Depends on dsa_pkg, dsa_if, dsa_front, dsa_back.
//
//  channel  dir  word
//  in_ch    in   action, handle_address, frame_slot
//  out_ch   out  status, cpu_address, gpu_address, slot_index
//  cfg      in   cfg_we, cfg_index, cfg_data
//
// Allocate reads the free stack, multiplies and adds; errors and unused actions skip to the result;
// free runs the 48-step divider; drain does one memory read and one stack write per pending slot.
// After reset the free stack is refilled with all MAX_SLOTS (1024) entries; in_ch.ready is low.
// A two-word queue separates intake from execution; a held result blocks intake
// only once the queue is full.
module descriptor_slot_allocator
(
    input  logic                         clk,
    input  logic                         rst_n,
    dsa_in_if.sink                       in_ch,
    dsa_out_if.source                    out_ch,
    input  logic                         cfg_we,
    input  logic [dsa_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [dsa_pkg::ADDR_W-1:0]   cfg_data
);

    dsa_pkg::cfg_t       cfg_reg, cfg_next;
    logic                q_valid, q_ready;
    dsa_pkg::cmd_t       q_word;
    dsa_pkg::back_stat_t bk_stat;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                dsa_pkg::CFG_CAPACITY: cfg_next.capacity = cfg_data[dsa_pkg::CAP_W-1:0];
                dsa_pkg::CFG_DSIZE:    cfg_next.dsize    = cfg_data[dsa_pkg::DSIZE_W-1:0];
                dsa_pkg::CFG_VISIBLE:  cfg_next.visible  = cfg_data[0];
                dsa_pkg::CFG_CPU_BASE: cfg_next.cpu_base = cfg_data;
                dsa_pkg::CFG_GPU_BASE: cfg_next.gpu_base = cfg_data;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.capacity <= dsa_pkg::CAP_W'(1024);
            cfg_reg.dsize    <= dsa_pkg::DSIZE_W'(32);
            cfg_reg.visible  <= 1'b0;
            cfg_reg.cpu_base <= '0;
            cfg_reg.gpu_base <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    dsa_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .hold    (bk_stat.clearing),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_word  (q_word)
    );

    dsa_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_word  (q_word),
        .out_ch  (out_ch),
        .stat    (bk_stat)
    );

    a_no_intake_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        bk_stat.clearing |-> !in_ch.ready)
        else $error("word accepted during stack refill");

    a_pop_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid && q_ready |=> !bk_stat.idle)
        else $error("back stayed idle after taking a word");

    a_error_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.status != dsa_pkg::ST_OK
        |-> out_ch.cpu_address == '0 && out_ch.gpu_address == '0
            && out_ch.slot_index == '0)
        else $error("error result carries nonzero fields");

endmodule

/* tb/sv/tb_descriptor_slot_allocator.sv */
// tb_descriptor_slot_allocator: self-checking bench for the descriptor slot allocator.
// Predicts each result word from a shadow of the free stack, pending lists and registers.
// Depends on dsa_pkg, dsa_if and descriptor_slot_allocator.
module tb_descriptor_slot_allocator;

    typedef struct {
        logic [dsa_pkg::ACT_W-1:0]   action;
        logic [dsa_pkg::ADDR_W-1:0]  addr;
        logic [dsa_pkg::FRAME_W-1:0] frame;
    } req_t;

    typedef struct {
        logic [dsa_pkg::STAT_W-1:0] status;
        logic [dsa_pkg::ADDR_W-1:0] cpu;
        logic [dsa_pkg::ADDR_W-1:0] gpu;
        logic [dsa_pkg::SLOT_W-1:0] slot;
    } rsp_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [dsa_pkg::CIDX_W-1:0] cfg_index;
    logic [dsa_pkg::ADDR_W-1:0] cfg_data;

    dsa_in_if  in_ch ();
    dsa_out_if out_ch ();

    descriptor_slot_allocator DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow registers and state
    logic [dsa_pkg::CAP_W-1:0]   sh_capacity;
    logic [dsa_pkg::DSIZE_W-1:0] sh_dsize;
    logic                        sh_visible;
    logic [dsa_pkg::ADDR_W-1:0]  sh_cpu_base;
    logic [dsa_pkg::ADDR_W-1:0]  sh_gpu_base;
    logic [dsa_pkg::SLOT_W-1:0]  free_stack [dsa_pkg::MAX_SLOTS];
    int unsigned                 used_count;
    logic [dsa_pkg::SLOT_W-1:0]  pend_slots [dsa_pkg::FRAME_COUNT][dsa_pkg::MAX_SLOTS];
    int unsigned                 pend_cnt [dsa_pkg::FRAME_COUNT];
    bit                          handed_out [dsa_pkg::MAX_SLOTS];

    req_t word_q [$];
    rsp_t result_q [$];
    int   errors;
    int   send_idle;
    int   recv_stall;
    logic hold_on;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic int unsigned eff_capacity();
        return (sh_capacity > dsa_pkg::MAX_SLOTS) ? dsa_pkg::MAX_SLOTS : int'(sh_capacity);
    endfunction

    function automatic rsp_t compute_result(req_t w);
        rsp_t r;
        int unsigned total;
        logic [dsa_pkg::ADDR_W-1:0] diff;
        logic [dsa_pkg::ADDR_W-1:0] offset;
        logic [dsa_pkg::ADDR_W-1:0] slot_wide;
        int unsigned s;
        r.status = dsa_pkg::ST_OK;
        r.cpu = '0;
        r.gpu = '0;
        r.slot = '0;
        total = 0;
        if (w.action == dsa_pkg::ACT_ALLOC)
        begin
            if (used_count >= eff_capacity() || used_count >= dsa_pkg::MAX_SLOTS)
            begin
                r.status = dsa_pkg::ST_FULL;
            end
            else
            begin
                s = free_stack[used_count];
                offset = dsa_pkg::ADDR_W'(s) * dsa_pkg::ADDR_W'(sh_dsize);
                used_count++;
                r.cpu = sh_cpu_base + offset;
                r.gpu = sh_visible ? sh_gpu_base + offset : '0;
                r.slot = dsa_pkg::SLOT_W'(s);
                handed_out[s] = 1'b1;
            end
        end
        else if (w.action == dsa_pkg::ACT_FREE)
        begin
            for (int f = 0; f < dsa_pkg::FRAME_COUNT; f++)
                total += pend_cnt[f];
            if (w.addr == '0)
            begin
                r.status = dsa_pkg::ST_NULL;
            end
            else if (total >= used_count)
            begin
                r.status = dsa_pkg::ST_EMPTY;
            end
            else if (w.frame >= dsa_pkg::FRAME_COUNT || sh_dsize == '0
                     || w.addr < sh_cpu_base)
            begin
                r.status = dsa_pkg::ST_BAD;
            end
            else
            begin
                diff = w.addr - sh_cpu_base;
                slot_wide = diff / dsa_pkg::ADDR_W'(sh_dsize);
                if (diff % dsa_pkg::ADDR_W'(sh_dsize) != '0
                    || slot_wide >= dsa_pkg::ADDR_W'(eff_capacity()))
                begin
                    r.status = dsa_pkg::ST_BAD;
                end
                else
                begin
                    pend_slots[w.frame][pend_cnt[w.frame]] = dsa_pkg::SLOT_W'(slot_wide);
                    pend_cnt[w.frame]++;
                    r.slot = dsa_pkg::SLOT_W'(slot_wide);
                    handed_out[slot_wide] = 1'b0;
                end
            end
        end
        else if (w.action == dsa_pkg::ACT_DRAIN)
        begin
            if (w.frame >= dsa_pkg::FRAME_COUNT)
            begin
                r.status = dsa_pkg::ST_BAD;
            end
            else
            begin
                for (int k = 0; k < pend_cnt[w.frame]; k++)
                begin
                    if (used_count == 0)
                        break;
                    used_count--;
                    free_stack[used_count] = pend_slots[w.frame][k];
                end
                pend_cnt[w.frame] = 0;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [dsa_pkg::ADDR_W-1:0] got,
                                   logic [dsa_pkg::ADDR_W-1:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // driver
    always @(posedge clk)
    begin
        req_t w;
        if (in_ch.valid && in_ch.ready)
        begin
            w = word_q.pop_front();
            result_q.push_back(compute_result(w));
        end
        if (in_ch.valid && !in_ch.ready)
        begin
            in_ch.valid <= 1'b1;
        end
        else if (rst_n && word_q.size() > 0 && $urandom_range(99) >= send_idle)
        begin
            in_ch.valid          <= 1'b1;
            in_ch.action         <= word_q[0].action;
            in_ch.handle_address <= word_q[0].addr;
            in_ch.frame_slot     <= word_q[0].frame;
        end
        else
        begin
            in_ch.valid <= 1'b0;
        end
    end

    // receiver
    always @(posedge clk)
    begin
        out_ch.ready <= !hold_on && ($urandom_range(99) >= recv_stall);
    end

    // monitor
    always @(posedge clk)
    begin
        rsp_t e;
        if (out_ch.valid && out_ch.ready)
        begin
            if (result_q.size() == 0)
            begin
                report_mismatch("unexpected word status",
                                dsa_pkg::ADDR_W'(out_ch.status), '0);
            end
            else
            begin
                e = result_q.pop_front();
                if (out_ch.status !== e.status)
                    report_mismatch("status", dsa_pkg::ADDR_W'(out_ch.status),
                                    dsa_pkg::ADDR_W'(e.status));
                if (out_ch.cpu_address !== e.cpu)
                    report_mismatch("cpu_address", out_ch.cpu_address, e.cpu);
                if (out_ch.gpu_address !== e.gpu)
                    report_mismatch("gpu_address", out_ch.gpu_address, e.gpu);
                if (out_ch.slot_index !== e.slot)
                    report_mismatch("slot_index", dsa_pkg::ADDR_W'(out_ch.slot_index),
                                    dsa_pkg::ADDR_W'(e.slot));
            end
        end
    end

    task automatic push_word(logic [dsa_pkg::ACT_W-1:0] a, logic [dsa_pkg::ADDR_W-1:0] adr,
                             logic [dsa_pkg::FRAME_W-1:0] f);
        req_t w;
        w.action = a;
        w.addr = adr;
        w.frame = f;
        word_q.push_back(w);
    endtask

    task automatic wait_idle();
        while (word_q.size() > 0 || in_ch.valid || result_q.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(logic [dsa_pkg::CIDX_W-1:0] idx,
                             logic [dsa_pkg::ADDR_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            dsa_pkg::CFG_CAPACITY: sh_capacity = data[dsa_pkg::CAP_W-1:0];
            dsa_pkg::CFG_DSIZE:    sh_dsize    = data[dsa_pkg::DSIZE_W-1:0];
            dsa_pkg::CFG_VISIBLE:  sh_visible  = data[0];
            dsa_pkg::CFG_CPU_BASE: sh_cpu_base = data;
            dsa_pkg::CFG_GPU_BASE: sh_gpu_base = data;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_words(int n);
        int r;
        int picks [$];
        int s;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 38)
            begin
                push_word(dsa_pkg::ACT_ALLOC, dsa_pkg::ADDR_W'({$urandom, $urandom}),
                          dsa_pkg::FRAME_W'($urandom));
            end
            else if (r < 75)
            begin
                picks = {};
                for (int k = 0; k < dsa_pkg::MAX_SLOTS; k++)
                    if (handed_out[k])
                        picks.push_back(k);
                if (picks.size() > 0 && $urandom_range(9) > 0)
                begin
                    s = picks[$urandom_range(picks.size() - 1)];
                    push_word(dsa_pkg::ACT_FREE,
                              sh_cpu_base + dsa_pkg::ADDR_W'(s) * dsa_pkg::ADDR_W'(sh_dsize),
                              dsa_pkg::FRAME_W'($urandom_range(dsa_pkg::FRAME_COUNT - 1)));
                end
                else
                begin
                    push_word(dsa_pkg::ACT_FREE,
                              sh_cpu_base
                              + dsa_pkg::ADDR_W'($urandom_range(dsa_pkg::MAX_SLOTS * 2))
                              * dsa_pkg::ADDR_W'(sh_dsize)
                              + dsa_pkg::ADDR_W'($urandom_range(1)),
                              dsa_pkg::FRAME_W'($urandom_range(dsa_pkg::FRAME_COUNT - 1)));
                end
            end
            else if (r < 88)
            begin
                push_word(dsa_pkg::ACT_DRAIN, '0,
                          dsa_pkg::FRAME_W'($urandom_range(dsa_pkg::FRAME_COUNT - 1)));
            end
            else
            begin
                push_word(dsa_pkg::ACT_W'($urandom), ($urandom_range(3) == 0) ? '0
                          : dsa_pkg::ADDR_W'({$urandom, $urandom}),
                          dsa_pkg::FRAME_W'($urandom));
            end
            if (word_q.size() > 12)
                while (word_q.size() > 2)
                    @(posedge clk);
        end
    endtask

    initial
    begin : stimulus
        int sent;
        int phase;
        logic [dsa_pkg::ADDR_W-1:0] base;
        errors      = 0;
        send_idle   = 0;
        recv_stall  = 0;
        hold_on     = 1'b0;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = dsa_pkg::CFG_CAPACITY;
        cfg_data    = '0;
        in_ch.valid = 1'b0;
        in_ch.action = dsa_pkg::ACT_ALLOC;
        in_ch.handle_address = '0;
        in_ch.frame_slot = '0;
        out_ch.ready = 1'b0;
        sh_capacity = dsa_pkg::CAP_W'(1024);
        sh_dsize    = dsa_pkg::DSIZE_W'(32);
        sh_visible  = 1'b0;
        sh_cpu_base = '0;
        sh_gpu_base = '0;
        for (int i = 0; i < dsa_pkg::MAX_SLOTS; i++)
        begin
            free_stack[i] = dsa_pkg::SLOT_W'(i);
            handed_out[i] = 1'b0;
        end
        used_count = 0;
        for (int f = 0; f < dsa_pkg::FRAME_COUNT; f++)
            pend_cnt[f] = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed words at reset settings
        push_word(dsa_pkg::ACT_FREE, '0, 2'd0);
        push_word(dsa_pkg::ACT_FREE, 48'd64, 2'd0);
        push_word(dsa_pkg::ACT_DRAIN, '0, 2'd3);
        push_word(dsa_pkg::ACT_DRAIN, '0, 2'd1);
        push_word(dsa_pkg::ACT_UNUSED, '1, 2'd3);
        push_word(dsa_pkg::ACT_ALLOC, '0, 2'd0);
        push_word(dsa_pkg::ACT_ALLOC, '0, 2'd0);
        push_word(dsa_pkg::ACT_ALLOC, '0, 2'd0);
        push_word(dsa_pkg::ACT_FREE, 48'd33, 2'd0);
        push_word(dsa_pkg::ACT_FREE, 48'd32, 2'd3);
        push_word(dsa_pkg::ACT_FREE, 48'd32768, 2'd0);
        push_word(dsa_pkg::ACT_FREE, '1, 2'd1);
        push_word(dsa_pkg::ACT_FREE, 48'd32, 2'd0);
        push_word(dsa_pkg::ACT_FREE, 48'd64, 2'd2);
        push_word(dsa_pkg::ACT_FREE, 48'd32, 2'd1);
        push_word(dsa_pkg::ACT_DRAIN, '0, 2'd0);
        push_word(dsa_pkg::ACT_DRAIN, '0, 2'd2);
        push_word(dsa_pkg::ACT_ALLOC, '0, 2'd0);
        sent = 18;
        wait_idle();

        write_reg(dsa_pkg::CFG_CAPACITY, 48'd1);
        write_reg(dsa_pkg::CFG_VISIBLE, 48'd1);
        write_reg(dsa_pkg::CFG_GPU_BASE, '1);
        write_reg(dsa_pkg::CFG_CPU_BASE, 48'h1000);
        push_word(dsa_pkg::ACT_ALLOC, '0, 2'd0);
        push_word(dsa_pkg::ACT_FREE, 48'h1000, 2'd0);
        push_word(dsa_pkg::ACT_FREE, 48'h0FFF, 2'd0);
        push_word(dsa_pkg::ACT_DRAIN, '0, 2'd0);
        push_word(dsa_pkg::ACT_ALLOC, '0, 2'd0);
        sent += 5;
        wait_idle();

        // long receiver hold while the sender keeps offering
        recv_stall = 0;
        write_reg(dsa_pkg::CFG_CAPACITY, 48'd2047);
        write_reg(dsa_pkg::CFG_DSIZE, 48'd4096);
        write_reg(dsa_pkg::CFG_CPU_BASE, '1 - 48'd100000);
        fork
            begin
                hold_on <= 1'b1;
                repeat (600) @(posedge clk);
                hold_on <= 1'b0;
            end
        join_none
        random_words(40);
        sent += 40;
        wait_idle();

        phase = 0;
        while (sent < 550)
        begin
            case (phase % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 57; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 57; end
                default: begin send_idle = 33; recv_stall = 33; end
            endcase
            case (phase % 6)
                0: write_reg(dsa_pkg::CFG_CAPACITY, 48'd1024);
                1: write_reg(dsa_pkg::CFG_CAPACITY, dsa_pkg::ADDR_W'($urandom_range(2, 40)));
                2: write_reg(dsa_pkg::CFG_CAPACITY, 48'd0);
                3: write_reg(dsa_pkg::CFG_CAPACITY, 48'd2047);
                4: write_reg(dsa_pkg::CFG_CAPACITY, 48'd1);
                default: write_reg(dsa_pkg::CFG_CAPACITY,
                                   dsa_pkg::ADDR_W'($urandom_range(1, 1024)));
            endcase
            case (phase % 5)
                0: write_reg(dsa_pkg::CFG_DSIZE, 48'd1);
                1: write_reg(dsa_pkg::CFG_DSIZE, 48'd4096);
                2: write_reg(dsa_pkg::CFG_DSIZE, (phase == 7) ? 48'd0 : 48'd8191);
                default: write_reg(dsa_pkg::CFG_DSIZE,
                                   dsa_pkg::ADDR_W'($urandom_range(1, 4096)));
            endcase
            write_reg(dsa_pkg::CFG_VISIBLE, dsa_pkg::ADDR_W'($urandom_range(1)));
            base = dsa_pkg::ADDR_W'({$urandom, $urandom});
            write_reg(dsa_pkg::CFG_CPU_BASE, (phase % 3 == 0) ? '0 : base);
            write_reg(dsa_pkg::CFG_GPU_BASE, (phase % 3 == 1) ? '1
                      : dsa_pkg::ADDR_W'({$urandom, $urandom}));
            random_words(45);
            sent += 45;
            wait_idle();
            phase++;
        end

        repeat (30) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin : watchdog
        #40000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
